[hdl/gripper_intake_sequencer_assert.svh]
// ----------------------------------------------------------------------------
// Gripper intake sequencer assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef GRIPPER_INTAKE_SEQUENCER_ASSERT_SVH
`define GRIPPER_INTAKE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define GIS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define GIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/gis_pkg.sv]
// ----------------------------------------------------------------------------
// Gripper intake sequencer package
// Shared types, register map and sequencer state codes.
// ----------------------------------------------------------------------------
package gis_pkg;

  localparam int PADDR_BITS = 5;
  localparam int REG_IDX_BITS = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_OPEN_DRIVE  = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_CLOSE_DRIVE = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_DOWN_DRIVE  = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_UP_DRIVE    = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_DOWN_LIMIT  = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_UP_LIMIT    = 3'd5;

  localparam logic signed [15:0] OPEN_DRIVE_RST  = 16'sd1000;
  localparam logic signed [15:0] CLOSE_DRIVE_RST = -16'sd1000;
  localparam logic signed [15:0] DOWN_DRIVE_RST  = 16'sd200;
  localparam logic signed [15:0] UP_DRIVE_RST    = -16'sd500;
  localparam logic signed [31:0] DOWN_LIMIT_RST  = -32'sd57577;
  localparam logic signed [31:0] UP_LIMIT_RST    = -32'sd13160;

  localparam logic [2:0] PH_OPEN  = 3'd0;
  localparam logic [2:0] PH_LOWER = 3'd1;
  localparam logic [2:0] PH_WAIT  = 3'd2;
  localparam logic [2:0] PH_CLOSE = 3'd3;
  localparam logic [2:0] PH_RAISE = 3'd4;
  localparam logic [2:0] PH_DONE  = 3'd5;

  typedef struct packed {
    logic [15:0] open_drive;
    logic [15:0] close_drive;
    logic [15:0] down_drive;
    logic [15:0] up_drive;
    logic [31:0] down_limit_steps;
    logic [31:0] up_limit_steps;
  } cfg_t;

  typedef struct packed {
    logic automation_enable;
    logic restart_button;
    logic open_switch;
    logic box_switch;
    logic closed_switch;
  } switches_t;

endpackage

[hdl/gis_regs.sv]
// ----------------------------------------------------------------------------
// Gripper intake sequencer configuration registers
// APB-style register file holding the drive commands and step limits.
// ----------------------------------------------------------------------------
module gis_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gis_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output gis_pkg::cfg_t                  cfg
);
  import gis_pkg::*;

  logic [REG_IDX_BITS-1:0] idx;
  logic                    wr_en;

  assign idx    = paddr[PADDR_BITS-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_drive       <= OPEN_DRIVE_RST;
      cfg.close_drive      <= CLOSE_DRIVE_RST;
      cfg.down_drive       <= DOWN_DRIVE_RST;
      cfg.up_drive         <= UP_DRIVE_RST;
      cfg.down_limit_steps <= DOWN_LIMIT_RST;
      cfg.up_limit_steps   <= UP_LIMIT_RST;
    end else if (wr_en) begin
      case (idx)
        REG_OPEN_DRIVE:  cfg.open_drive       <= pwdata[15:0];
        REG_CLOSE_DRIVE: cfg.close_drive      <= pwdata[15:0];
        REG_DOWN_DRIVE:  cfg.down_drive       <= pwdata[15:0];
        REG_UP_DRIVE:    cfg.up_drive         <= pwdata[15:0];
        REG_DOWN_LIMIT:  cfg.down_limit_steps <= pwdata;
        REG_UP_LIMIT:    cfg.up_limit_steps   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_OPEN_DRIVE:  prdata = 32'($signed(cfg.open_drive));
      REG_CLOSE_DRIVE: prdata = 32'($signed(cfg.close_drive));
      REG_DOWN_DRIVE:  prdata = 32'($signed(cfg.down_drive));
      REG_UP_DRIVE:    prdata = 32'($signed(cfg.up_drive));
      REG_DOWN_LIMIT:  prdata = cfg.down_limit_steps;
      REG_UP_LIMIT:    prdata = cfg.up_limit_steps;
      default:         prdata = '0;
    endcase
  end

endmodule

[hdl/gis_encoder.sv]
// ----------------------------------------------------------------------------
// Gripper intake sequencer encoder tracker
// Unwraps the quadrature count difference and keeps a saturating step total.
// ----------------------------------------------------------------------------
module gis_encoder #(
  parameter int COUNT_BITS = 16,
  parameter int STEP_BITS  = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step_en,
  input  logic [COUNT_BITS-1:0]       count,
  output logic signed [STEP_BITS-1:0] steps_next,
  output logic signed [STEP_BITS-1:0] steps
);
  import gis_pkg::*;

  localparam int W = ((STEP_BITS > COUNT_BITS + 1) ? STEP_BITS : COUNT_BITS + 1) + 1;
  localparam logic signed [COUNT_BITS:0] HALF     = {2'b01, {(COUNT_BITS-1){1'b0}}};
  localparam logic signed [COUNT_BITS:0] NEG_HALF = {2'b11, {(COUNT_BITS-1){1'b0}}};
  localparam logic signed [W-1:0] SMAX = {{(W-STEP_BITS+1){1'b0}}, {(STEP_BITS-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = ~SMAX;

  logic [COUNT_BITS-1:0]       last_count;
  logic                        count_seen;
  logic [COUNT_BITS-1:0]       prev;
  logic signed [COUNT_BITS:0]  diff;
  logic signed [COUNT_BITS:0]  delta;
  logic signed [W-1:0]         wide;

  assign prev = count_seen ? last_count : count;
  assign diff = $signed({1'b0, count}) - $signed({1'b0, prev});

  always_comb begin
    if (diff > HALF || diff < NEG_HALF) begin
      delta = {~diff[COUNT_BITS], diff[COUNT_BITS-1:0]};
    end else begin
      delta = diff;
    end
    wide = W'(steps) - W'(delta);
    if (wide > SMAX) begin
      steps_next = STEP_BITS'(SMAX);
    end else if (wide < SMIN) begin
      steps_next = STEP_BITS'(SMIN);
    end else begin
      steps_next = STEP_BITS'(wide);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_count <= '0;
      count_seen <= 1'b0;
      steps      <= '0;
    end else if (step_en) begin
      last_count <= count;
      count_seen <= 1'b1;
      steps      <= steps_next;
    end
  end

endmodule

[hdl/gis_sequencer.sv]
// ----------------------------------------------------------------------------
// Gripper intake sequencer state machine
// Six-state open, lower, wait, close, raise and done sequence with held drives.
// ----------------------------------------------------------------------------
module gis_sequencer #(
  parameter int STEP_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step_en,
  input  gis_pkg::switches_t          sw,
  input  gis_pkg::cfg_t               cfg,
  input  logic signed [STEP_BITS-1:0] steps_next,
  output logic [2:0]                  phase,
  output logic signed [15:0]          grip_cmd,
  output logic signed [15:0]          rotate_cmd
);
  import gis_pkg::*;

  localparam int CMP_BITS = (STEP_BITS > 32) ? STEP_BITS : 32;

  logic [2:0]                 phase_next;
  logic                       first_box_held;
  logic                       first_box_held_next;
  logic signed [15:0]         grip_cmd_next;
  logic signed [15:0]         rotate_cmd_next;
  logic [2:0]                 cur;
  logic signed [CMP_BITS-1:0] steps_cmp;
  logic signed [CMP_BITS-1:0] down_cmp;
  logic signed [CMP_BITS-1:0] up_cmp;

  assign steps_cmp = CMP_BITS'(steps_next);
  assign down_cmp  = CMP_BITS'($signed(cfg.down_limit_steps));
  assign up_cmp    = CMP_BITS'($signed(cfg.up_limit_steps));

  always_comb begin
    phase_next          = phase;
    first_box_held_next = first_box_held;
    grip_cmd_next       = grip_cmd;
    rotate_cmd_next     = rotate_cmd;
    cur                 = phase;
    if (sw.automation_enable) begin
      if (sw.restart_button) begin
        cur                 = PH_OPEN;
        first_box_held_next = 1'b0;
      end
      phase_next = cur;
      case (cur)
        PH_OPEN: begin
          if (sw.open_switch) begin
            grip_cmd_next = cfg.open_drive;
          end else begin
            grip_cmd_next = '0;
            phase_next    = PH_LOWER;
          end
        end
        PH_LOWER: begin
          if (steps_cmp > down_cmp) begin
            rotate_cmd_next = cfg.down_drive;
          end else begin
            rotate_cmd_next = '0;
            phase_next      = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (sw.box_switch) begin
            phase_next = PH_CLOSE;
          end
        end
        PH_CLOSE: begin
          if (sw.closed_switch) begin
            grip_cmd_next = cfg.close_drive;
          end else begin
            grip_cmd_next = '0;
            phase_next    = first_box_held_next ? PH_DONE : PH_RAISE;
          end
        end
        PH_RAISE: begin
          if (steps_cmp < up_cmp) begin
            rotate_cmd_next = cfg.up_drive;
          end else begin
            rotate_cmd_next     = '0;
            first_box_held_next = 1'b1;
            phase_next          = PH_OPEN;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_OPEN;
      first_box_held <= 1'b0;
      grip_cmd       <= '0;
      rotate_cmd     <= '0;
    end else if (step_en) begin
      phase          <= phase_next;
      first_box_held <= first_box_held_next;
      grip_cmd       <= grip_cmd_next;
      rotate_cmd     <= rotate_cmd_next;
    end
  end

endmodule

[hdl/gripper_intake_sequencer.sv]
// ----------------------------------------------------------------------------
// Gripper intake sequencer
// Encoder step tracking and box intake sequencing, one result per tick.
// ----------------------------------------------------------------------------
// Each input transaction carries one tick: a raw wrapping encoder count and
// the switch levels. Each tick produces exactly one output transaction with
// the held grip and rotate commands, the sequencer state and the step total.
// The input transaction is captured in an input register. Once the result
// register is free or being taken, one pass of logic updates the step total,
// the sequencer and the result register together, and the new result is then
// presented for the receiver to take.
// A new tick is accepted every cycle as long as results are taken.
// When the receiver stalls, the result holds and one further tick waits in
// the input register; in_ready drops only when both are full.
// Reset clears the step total, the sequencer (opening state), the commands
// and the pipeline, and loads the default drive values and step limits.
// The APB-style port writes the configuration with zero wait states.
// ----------------------------------------------------------------------------
module gripper_intake_sequencer #(
  parameter int COUNT_BITS = 16,
  parameter int STEP_BITS  = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [COUNT_BITS-1:0]          encoder_count,
  input  logic                           automation_enable,
  input  logic                           restart_button,
  input  logic                           open_switch,
  input  logic                           box_switch,
  input  logic                           closed_switch,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [15:0]             grip_drive,
  output logic signed [15:0]             rotate_drive,
  output logic [2:0]                     sequence_state,
  output logic signed [31:0]             step_total,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gis_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import gis_pkg::*;

  logic                        s1_valid;
  logic                        s1_valid_next;
  logic [COUNT_BITS-1:0]       s1_count;
  switches_t                   s1_sw;
  logic                        out_valid_next;
  logic                        advance;
  logic                        in_accept;
  cfg_t                        cfg;
  logic signed [STEP_BITS-1:0] steps_next;
  logic signed [STEP_BITS-1:0] steps;

  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    if (in_accept) begin
      s1_valid_next = 1'b1;
    end else if (advance) begin
      s1_valid_next = 1'b0;
    end else begin
      s1_valid_next = s1_valid;
    end
    if (advance) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_count                <= encoder_count;
      s1_sw.automation_enable <= automation_enable;
      s1_sw.restart_button    <= restart_button;
      s1_sw.open_switch       <= open_switch;
      s1_sw.box_switch        <= box_switch;
      s1_sw.closed_switch     <= closed_switch;
    end
  end

  gis_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gis_encoder #(
    .COUNT_BITS (COUNT_BITS),
    .STEP_BITS  (STEP_BITS)
  ) u_encoder (
    .clk        (clk),
    .rst        (rst),
    .step_en    (advance),
    .count      (s1_count),
    .steps_next (steps_next),
    .steps      (steps)
  );

  gis_sequencer #(
    .STEP_BITS (STEP_BITS)
  ) u_sequencer (
    .clk        (clk),
    .rst        (rst),
    .step_en    (advance),
    .sw         (s1_sw),
    .cfg        (cfg),
    .steps_next (steps_next),
    .phase      (sequence_state),
    .grip_cmd   (grip_drive),
    .rotate_cmd (rotate_drive)
  );

  assign step_total = 32'(steps);

endmodule

[hdl/gis_checker.sv]
// ----------------------------------------------------------------------------
// Gripper intake sequencer port checker
// Port-level checks on results and the output handshake, bound to the top.
// ----------------------------------------------------------------------------
`include "gripper_intake_sequencer_assert.svh"

module gis_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [15:0] grip_drive,
  input logic signed [15:0] rotate_drive,
  input logic [2:0]        sequence_state
);
  import gis_pkg::*;

  `GIS_ASSERT_NOW(a_state_legal, out_valid, sequence_state <= PH_DONE, "illegal sequence state")

  `GIS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(sequence_state) && $stable(grip_drive) && $stable(rotate_drive),
    "stalled output transaction changed")

  `GIS_ASSERT_NOW(a_grip_idle,
    out_valid && (sequence_state == PH_LOWER || sequence_state == PH_WAIT ||
                  sequence_state == PH_RAISE || sequence_state == PH_DONE),
    grip_drive == 16'sd0, "grip drive active outside open and close")

  `GIS_ASSERT_NOW(a_rotate_idle,
    out_valid && (sequence_state == PH_WAIT || sequence_state == PH_CLOSE ||
                  sequence_state == PH_DONE),
    rotate_drive == 16'sd0, "rotate drive active while gripper parked")

  `GIS_ASSERT_NEXT(a_done_exit, out_valid && out_ready && sequence_state == PH_DONE,
    !out_valid || sequence_state == PH_DONE || sequence_state == PH_OPEN ||
    sequence_state == PH_LOWER, "done state left without restart")

endmodule

bind gripper_intake_sequencer gis_checker u_checker (.*);
